FILE: hdl/spims_pkg.sv
// Shared types, constants and helpers for the SPI master shift engine.
package spims_pkg;

  localparam int MAX_WORD_BITS = 16;
  localparam int WORD_W        = 16;
  localparam int POS_W         = $clog2(WORD_W);
  localparam int LEN_W         = POS_W + 1;
  localparam int HALF_W        = 7;
  localparam int HALF_MAX      = 64;
  localparam int SHORT_BITS    = 8;
  localparam int LONG_BITS     = (MAX_WORD_BITS < 16) ? MAX_WORD_BITS : 16;
  localparam int SHORT_LEN     = (MAX_WORD_BITS < SHORT_BITS) ? MAX_WORD_BITS : SHORT_BITS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HALF_W;

  localparam logic [CFG_IDX_W-1:0] REG_SPI_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_16     = 2'd3;

  typedef struct packed {
    logic [1:0]        spi_mode;
    logic              lsb_first;
    logic [HALF_W-1:0] half_period;
    logic              word_16;
  } spims_cfg_t;

  typedef struct packed {
    logic              start_req;
    logic [WORD_W-1:0] tx_word;
    logic              miso;
  } spims_in_t;

  typedef struct packed {
    logic              sclk;
    logic              mosi;
    logic              busy_res;
    logic              done_res;
    logic [WORD_W-1:0] rx_word;
  } spims_res_t;

  function automatic logic [POS_W-1:0] bit_pos(input logic lsb, input logic [POS_W-1:0] idx,
                                                input logic [LEN_W-1:0] len);
    logic [POS_W-1:0] last;
    last = len[POS_W-1:0] - POS_W'(1);
    return lsb ? idx : (last - idx);
  endfunction

endpackage

FILE: hdl/spims_if.sv
// Valid/ready channel interfaces for the input and result words.
interface spims_in_if;
  logic                          valid;
  logic                          ready;
  logic                          start_req;
  logic [spims_pkg::WORD_W-1:0]  tx_word;
  logic                          miso;

  modport source (output valid, output start_req, output tx_word, output miso, input ready);
  modport sink   (input valid, input start_req, input tx_word, input miso, output ready);
endinterface

interface spims_out_if;
  logic                          valid;
  logic                          ready;
  logic                          sclk;
  logic                          mosi;
  logic                          busy_res;
  logic                          done_res;
  logic [spims_pkg::WORD_W-1:0]  rx_word;

  modport source (output valid, output sclk, output mosi, output busy_res, output done_res,
                  output rx_word, input ready);
  modport sink   (input valid, input sclk, input mosi, input busy_res, input done_res,
                  input rx_word, output ready);
endinterface

FILE: hdl/spims_core.sv
// Frame state and per-tick next-state logic of the SPI master.
module spims_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  spims_pkg::spims_in_t  in_word,
  input  spims_pkg::spims_cfg_t cfg,
  output spims_pkg::spims_res_t res
);
  import spims_pkg::*;

  logic [WORD_W-1:0] tx_r, tx_nxt;
  logic [WORD_W-1:0] rx_r, rx_nxt;
  logic [POS_W-1:0]  bc_r, bc_nxt;
  logic [HALF_W-1:0] tick_r, tick_nxt;
  logic              phase_r, phase_nxt;
  logic              active_r, active_nxt;
  logic              mosi_r, mosi_nxt;

  logic              cpol, cpha;
  logic [LEN_W-1:0]  len;
  logic [WORD_W-1:0] mask;
  logic [HALF_W-1:0] ht;
  logic [WORD_W-1:0] tx_load;
  logic [LEN_W-1:0]  bc_inc;
  logic              done;
  logic [WORD_W-1:0] rx_out;

  assign cpol    = cfg.spi_mode[1];
  assign cpha    = cfg.spi_mode[0];
  assign len     = cfg.word_16 ? LEN_W'(LONG_BITS) : LEN_W'(SHORT_LEN);
  assign mask    = (len >= LEN_W'(WORD_W)) ? '1 : ((WORD_W'(1) << len) - WORD_W'(1));
  assign ht      = (cfg.half_period == '0) ? HALF_W'(1) :
                   (cfg.half_period > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : cfg.half_period;
  assign tx_load = in_word.tx_word & mask;
  assign bc_inc  = {1'b0, bc_r} + LEN_W'(1);

  always_comb begin
    tx_nxt     = tx_r;
    rx_nxt     = rx_r;
    bc_nxt     = bc_r;
    tick_nxt   = tick_r;
    phase_nxt  = phase_r;
    active_nxt = active_r;
    mosi_nxt   = mosi_r;
    done       = 1'b0;
    rx_out     = '0;
    if (!active_r) begin
      if (in_word.start_req) begin
        tx_nxt     = tx_load;
        rx_nxt     = '0;
        bc_nxt     = '0;
        tick_nxt   = '0;
        phase_nxt  = 1'b0;
        active_nxt = 1'b1;
        mosi_nxt   = tx_load[bit_pos(cfg.lsb_first, '0, len)];
      end
    end else begin
      tick_nxt = tick_r + HALF_W'(1);
      if (tick_nxt >= ht) begin
        tick_nxt = '0;
        if (!phase_r) begin
          phase_nxt = 1'b1;
          if ({1'b0, bc_r} < len) begin
            rx_nxt = rx_r | (WORD_W'(in_word.miso) << bit_pos(cfg.lsb_first, bc_r, len));
          end
        end else if (bc_inc >= len) begin
          active_nxt = 1'b0;
          done       = 1'b1;
          rx_out     = rx_r & mask;
          bc_nxt     = '0;
          phase_nxt  = 1'b0;
        end else begin
          bc_nxt    = bc_r + POS_W'(1);
          phase_nxt = 1'b0;
          mosi_nxt  = tx_r[bit_pos(cfg.lsb_first, bc_nxt, len)];
        end
      end
    end
  end

  always_comb begin
    res.sclk     = active_nxt ? (cpol ^ cpha ^ phase_nxt) : cpol;
    res.mosi     = mosi_nxt;
    res.busy_res = active_nxt;
    res.done_res = done;
    res.rx_word  = rx_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r     <= '0;
      rx_r     <= '0;
      bc_r     <= '0;
      tick_r   <= '0;
      phase_r  <= 1'b0;
      active_r <= 1'b0;
      mosi_r   <= 1'b0;
    end else if (step) begin
      tx_r     <= tx_nxt;
      rx_r     <= rx_nxt;
      bc_r     <= bc_nxt;
      tick_r   <= tick_nxt;
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      mosi_r   <= mosi_nxt;
    end
  end

  ap_done_from_active: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |-> active_r)
    else $error("done raised outside a frame");
  ap_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && !active_r && !in_word.start_req |=> !active_r)
    else $error("frame began without a start request");
  ap_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r < HALF_W'(HALF_MAX))
    else $error("tick counter ran past the longest half period");

endmodule

FILE: hdl/spi_master_shift_engine_top.sv
// Top level of the SPI master shift engine: config registers and result buffer.
//
// Usage:
//   in_ch  : one word per clock tick of the bit timing (start_req, tx_word, miso).
//   out_ch : one result word per input word (sclk, mosi, busy_res, done_res, rx_word).
//   cfg_*  : write port; index 0 spi_mode, 1 lsb_first, 2 half_period, 3 word_16.
//            Write only while the engine is idle and the result buffer is drained.
// Result path: with the buffer empty, a result appears on out_ch in the cycle after its
//   input word is taken.
// Throughput: one word per cycle while in_ch.ready is high; the per-tick update is one
//   pass of counter compare and bit select between frame state and result register.
// Stall: a two-entry result buffer keeps in_ch.ready high while one result waits;
//   in_ch.ready drops only when both entries are full, and no result is lost.
// Reset: rst_n low (synchronous) idles the engine, empties the buffer and loads
//   spi_mode 0, lsb_first 0, half_period 1, word_16 0.
// A frame holds busy_res for 2 * half_period * bits ticks from its start tick, with
//   half_period taken as 1 to 64; done_res and rx_word come on the tick after.
module spi_master_shift_engine_top (
  input  logic                              clk,
  input  logic                              rst_n,
  spims_in_if.sink                          in_ch,
  spims_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [spims_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spims_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spims_pkg::*;

  spims_cfg_t cfg_r;
  spims_in_t  in_word;
  spims_res_t res;
  spims_res_t out_r, skid_r;
  logic       ov_r, sv_r;
  logic       in_fire, out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spi_mode    <= 2'd0;
      cfg_r.lsb_first   <= 1'b0;
      cfg_r.half_period <= HALF_W'(1);
      cfg_r.word_16     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPI_MODE:    cfg_r.spi_mode    <= cfg_data[1:0];
        REG_LSB_FIRST:   cfg_r.lsb_first   <= cfg_data[0];
        REG_HALF_PERIOD: cfg_r.half_period <= cfg_data[HALF_W-1:0];
        REG_WORD_16:     cfg_r.word_16     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_word.start_req = in_ch.start_req;
  assign in_word.tx_word   = in_ch.tx_word;
  assign in_word.miso      = in_ch.miso;

  assign in_ch.ready = !sv_r;
  assign in_fire     = in_ch.valid && !sv_r;
  assign out_fire    = ov_r && out_ch.ready;

  spims_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .in_word (in_word),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (out_fire) begin
      if (sv_r) begin
        sv_r <= 1'b0;
      end else if (!in_fire) begin
        ov_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!ov_r) begin
        ov_r <= 1'b1;
      end else begin
        sv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (sv_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      if (!ov_r) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.sclk     = out_r.sclk;
  assign out_ch.mosi     = out_r.mosi;
  assign out_ch.busy_res = out_r.busy_res;
  assign out_ch.done_res = out_r.done_res;
  assign out_ch.rx_word  = out_r.rx_word;

  ap_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid entry held while output register empty");
  ap_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready && in_fire |=> sv_r)
    else $error("accepted word lost while output stalled");
  ap_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_r.done_res |-> !out_r.busy_res)
    else $error("done result still marked busy");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SPI master shift engine: random ticks, stalls and checks.
module testbench;
  import spims_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spims_in_if  in_ch ();
  spims_out_if out_ch ();

  spi_master_shift_engine_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spims_in_t  tick_q[$];
  spims_res_t pin_q[$];
  int unsigned err_count;

  logic [1:0]        cfg_mode;
  logic              cfg_lsb;
  logic [HALF_W-1:0] cfg_half;
  logic              cfg_w16;

  logic        frame_on;
  logic        second_half;
  logic        mosi_q;
  logic [15:0] sh_tx;
  logic [15:0] sh_rx;
  int unsigned bit_idx;
  int unsigned tick_idx;

  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] ready_pat;
  int unsigned pat_left;
  spims_res_t  got;
  spims_res_t  want;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned wire_pos(input int unsigned idx, input int unsigned nbits);
    return (cfg_lsb ? idx : (nbits - 1 - idx)) & 15;
  endfunction

  function automatic spims_res_t spi_tick(input spims_in_t w);
    spims_res_t  r;
    int unsigned nbits;
    int unsigned limit;
    logic [15:0] mask;
    r = '0;
    nbits = cfg_w16 ? 16 : 8;
    if (nbits > MAX_WORD_BITS) nbits = MAX_WORD_BITS;
    mask = (nbits >= 16) ? 16'hFFFF : 16'((32'd1 << nbits) - 1);
    limit = (cfg_half == 0) ? 1 : ((cfg_half > 64) ? 64 : int'(cfg_half));
    if (!frame_on) begin
      if (w.start_req) begin
        sh_tx = w.tx_word & mask;
        sh_rx = '0;
        bit_idx = 0;
        tick_idx = 0;
        second_half = 1'b0;
        frame_on = 1'b1;
        mosi_q = sh_tx[wire_pos(0, nbits)];
      end
    end else begin
      tick_idx = (tick_idx + 1) & 127;
      if (tick_idx >= limit) begin
        tick_idx = 0;
        if (!second_half) begin
          second_half = 1'b1;
          if (bit_idx < nbits) sh_rx = sh_rx | (16'(w.miso) << wire_pos(bit_idx, nbits));
        end else if (bit_idx + 1 >= nbits) begin
          frame_on = 1'b0;
          r.done_res = 1'b1;
          r.rx_word = sh_rx & mask;
          bit_idx = 0;
          second_half = 1'b0;
        end else begin
          bit_idx = (bit_idx + 1) & 31;
          second_half = 1'b0;
          mosi_q = sh_tx[wire_pos(bit_idx, nbits)];
        end
      end
    end
    r.sclk = frame_on ? (cfg_mode[1] ^ cfg_mode[0] ^ second_half) : cfg_mode[1];
    r.mosi = mosi_q;
    r.busy_res = frame_on;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got_v, want_v, $realtime);
    err_count++;
  endtask

  task automatic push_tick(input logic start, input logic [15:0] tx, input logic miso);
    spims_in_t w;
    w.start_req = start;
    w.tx_word = tx;
    w.miso = miso;
    tick_q.push_back(w);
  endtask

  task automatic queue_random(input int unsigned count, input int unsigned odds);
    repeat (count) push_tick($urandom_range(0, odds) == 0, 16'($urandom), $urandom_range(0, 1));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SPI_MODE:    cfg_mode = val[1:0];
      REG_LSB_FIRST:   cfg_lsb = val[0];
      REG_HALF_PERIOD: cfg_half = val[HALF_W-1:0];
      REG_WORD_16:     cfg_w16 = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Finish the frame in flight and drain every result.
  task automatic settle;
    do begin
      while (tick_q.size() != 0 || pin_q.size() != 0) @(posedge clk);
      if (frame_on) repeat (8) push_tick(1'b0, 16'($urandom), $urandom_range(0, 1));
    end while (frame_on || tick_q.size() != 0);
  endtask

  task automatic run_phase(input logic [1:0] mode, input logic lsb, input logic [6:0] half,
                           input logic w16, input int unsigned count, input int unsigned odds);
    settle();
    write_reg(REG_SPI_MODE, CFG_DATA_W'(mode));
    write_reg(REG_LSB_FIRST, CFG_DATA_W'(lsb));
    write_reg(REG_HALF_PERIOD, CFG_DATA_W'(half));
    write_reg(REG_WORD_16, CFG_DATA_W'(w16));
    push_tick(1'b1, 16'($urandom), $urandom_range(0, 1));
    queue_random(count - 1, odds);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) pin_q.push_back(spi_tick(tick_q.pop_front()));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.start_req <= tick_q[0].start_req;
          in_ch.tx_word <= tick_q[0].tx_word;
          in_ch.miso <= tick_q[0].miso;
          burst_left--;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_pat = '1;
      pat_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.sclk = out_ch.sclk;
        got.mosi = out_ch.mosi;
        got.busy_res = out_ch.busy_res;
        got.done_res = out_ch.done_res;
        got.rx_word = out_ch.rx_word;
        if (pin_q.size() == 0) begin
          report_mismatch("unexpected word", got, 0);
        end else begin
          want = pin_q.pop_front();
          if (got.sclk !== want.sclk) report_mismatch("sclk", got.sclk, want.sclk);
          if (got.mosi !== want.mosi) report_mismatch("mosi", got.mosi, want.mosi);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
          if (got.rx_word !== want.rx_word)
            report_mismatch("rx_word", got.rx_word, want.rx_word);
        end
      end
      if (pat_left == 0) begin
        pat_left = $urandom_range(20, 200);
        ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      pat_left--;
      out_ch.ready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned waited;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.start_req = 1'b0;
    in_ch.tx_word = '0;
    in_ch.miso = 1'b0;
    out_ch.ready = 1'b0;
    err_count = 0;
    cfg_mode = 2'd0;
    cfg_lsb = 1'b0;
    cfg_half = 7'd1;
    cfg_w16 = 1'b0;
    frame_on = 1'b0;
    second_half = 1'b0;
    mosi_q = 1'b0;
    sh_tx = '0;
    sh_rx = '0;
    bit_idx = 0;
    tick_idx = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle tick, full-width word masked to a byte, starts while busy
    // and a zero-word start on the done tick, then idle ticks.
    push_tick(1'b0, 16'h0000, 1'b0);
    push_tick(1'b1, 16'hFFFF, 1'b1);
    repeat (15) push_tick(1'b1, 16'h5A5A, 1'b1);
    push_tick(1'b1, 16'h0000, 1'b0);
    repeat (7) push_tick(1'b0, 16'hFFFF, 1'b0);
    queue_random(40, 3);

    run_phase(2'd1, 1'b1, 7'd2, 1'b1, 40, 3);
    run_phase(2'd2, 1'b0, 7'd3, 1'b0, 40, 2);
    run_phase(2'd3, 1'b1, 7'd1, 1'b1, 40, 4);
    run_phase(2'd0, 1'b1, 7'd0, 1'b0, 30, 3);
    run_phase(2'd2, 1'b1, 7'd127, 1'b0, 1025, 50);
    repeat (4) begin
      run_phase(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 7'($urandom_range(1, 4)),
                1'($urandom_range(0, 1)), 30, $urandom_range(1, 6));
    end

    waited = 0;
    while ((tick_q.size() != 0 || pin_q.size() != 0) && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (tick_q.size() != 0) report_mismatch("words not taken", tick_q.size(), 0);
    if (pin_q.size() != 0) report_mismatch("results missing", pin_q.size(), 0);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
